// File: rtl/tiqs_pkg.sv
// shared constants, codes and control structs of the thread id queue set
`timescale 1ns / 1ps

package tiqs_pkg;

    localparam int DEF_QUEUE_DEPTH      = 16;
    localparam int DEF_ID_WIDTH         = 8;
    localparam int DEF_NUM_READY_QUEUES = 3;

    localparam int REQ_W    = 2;
    localparam int SEL_W    = 2;
    localparam int TID_W    = 8;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 2;
    localparam int COUNT_W  = 5;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd3;

    typedef struct packed {
        logic cmp_en;
        logic load_en;
        logic shift_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } queue_op_t;

endpackage

// File: rtl/tiqs_cell.sv
// one queue slot: holds an id, registers its key match and shifts toward the head
`timescale 1ns / 1ps

module tiqs_cell #(
    parameter int ID_W = tiqs_pkg::DEF_ID_WIDTH
) (
    input  logic                 clk,
    input  tiqs_pkg::cell_ctrl_t ctrl,
    input  logic                 occupied,
    input  logic [ID_W-1:0]      cmp_key,
    input  logic [ID_W-1:0]      load_key,
    input  logic [ID_W-1:0]      next_id,
    input  logic                 shift_in,
    output logic                 shift_out,
    output logic [ID_W-1:0]      id
);
    import tiqs_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic            match_reg;

    assign shift_out = shift_in | match_reg;
    assign id        = id_reg;

    always_comb
    begin
        id_next = id_reg;
        if (ctrl.load_en)
        begin
            id_next = load_key;
        end
        else if (ctrl.shift_en && shift_out)
        begin
            id_next = next_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        if (ctrl.cmp_en)
        begin
            match_reg <= occupied && (id_reg == cmp_key);
        end
    end

endmodule

// File: rtl/tiqs_queue.sv
// one ordered queue: a row of slot cells plus its fill count
`timescale 1ns / 1ps

module tiqs_queue #(
    parameter int DEPTH = tiqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_W  = tiqs_pkg::DEF_ID_WIDTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmp_en,
    input  logic [ID_W-1:0]     cmp_key,
    input  logic [ID_W-1:0]     load_key,
    input  tiqs_pkg::queue_op_t op,
    output logic                hit,
    output logic [CNT_W-1:0]    len
);
    import tiqs_pkg::*;

    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;
    logic             insert_go;
    logic             remove_go;
    logic [ID_W-1:0]  ids [DEPTH];
    logic [DEPTH:0]   shift_chain;

    assign shift_chain[0] = 1'b0;
    assign hit            = shift_chain[DEPTH];
    assign len            = len_reg;
    assign insert_go      = op.insert && !hit && (len_reg < CNT_W'(DEPTH));
    assign remove_go      = op.remove && hit;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t      ctrl;
        logic [ID_W-1:0] next_id;

        assign ctrl.cmp_en   = cmp_en;
        assign ctrl.load_en  = insert_go && (len_reg == CNT_W'(i));
        assign ctrl.shift_en = remove_go;

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_id = ids[i];
        end
        else
        begin : g_body
            assign next_id = ids[i+1];
        end

        tiqs_cell #(
            .ID_W (ID_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (CNT_W'(i) < len_reg),
            .cmp_key   (cmp_key),
            .load_key  (load_key),
            .next_id   (next_id),
            .shift_in  (shift_chain[i]),
            .shift_out (shift_chain[i+1]),
            .id        (ids[i])
        );
    end

    always_comb
    begin
        len_next = len_reg;
        if (insert_go)
        begin
            len_next = len_reg + CNT_W'(1);
        end
        else if (remove_go)
        begin
            len_next = len_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

endmodule

// File: rtl/thread_id_queue_set_unit.sv
// top level of the thread id queue set: request decode, queue rows and result register
`timescale 1ns / 1ps

// Keeps NUM_READY_QUEUES ready queues and one blocked queue of thread ids.
// Input channel s_axis carries one request per transaction: insert at tail,
// remove by id, or search all queues (ready queues in order, then blocked).
// Output channel m_axis carries exactly one result per request: status,
// queue that holds the id on a search, and entries left in the chosen queue.
// Timing: a request is accepted in the idle state; in that same cycle every
// slot cell compares its id with the key. The next cycle resolves the match
// chain, shifts or loads the cells and loads the result register. A new
// request is taken only after that apply state, one compare / apply
// sequence through the cell rows at a time.
// The result register lets the next request be accepted while a result
// waits; if m_axis stalls, that request holds in its apply cycle until the
// result register is free. Reset empties all queues at once (fill counts
// only); slot contents need no clearing, nothing is read past a queue's fill.
module thread_id_queue_set_unit #(
    parameter int QUEUE_DEPTH      = tiqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH         = tiqs_pkg::DEF_ID_WIDTH,
    parameter int NUM_READY_QUEUES = tiqs_pkg::DEF_NUM_READY_QUEUES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // req_type [1:0], list_select [3:2], thread_id [11:4], zero [15:12]
    input  logic [tiqs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status [1:0], found_queue [3:2], entry_count [8:4], zero [15:9]
    output logic [tiqs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tiqs_pkg::*;

    localparam int NQ    = NUM_READY_QUEUES + 1;
    localparam int QW    = $clog2(NQ);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [REQ_W-1:0]    req_reg;
    logic [QW-1:0]       q_reg;
    logic [ID_WIDTH-1:0] key_reg;

    logic [REQ_W-1:0]    in_req;
    logic [SEL_W-1:0]    in_sel;
    logic [TID_W-1:0]    in_tid;
    logic [ID_WIDTH-1:0] in_key;
    logic [QW-1:0]       in_q;
    logic                accept;
    logic                go;

    logic [NQ-1:0]       hit_vec;
    logic [CNT_W-1:0]    len_vec [NQ];
    queue_op_t           op_vec  [NQ];

    logic                sel_hit;
    logic [CNT_W-1:0]    sel_len;
    logic [STATUS_W-1:0] res_status;
    logic [FOUND_W-1:0]  res_found;
    logic [CNT_W-1:0]    res_cnt;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [FOUND_W-1:0]  found_reg;
    logic [COUNT_W-1:0]  count_reg;

    assign in_req = s_axis_tdata[REQ_W-1:0];
    assign in_sel = s_axis_tdata[REQ_W+SEL_W-1:REQ_W];
    assign in_tid = s_axis_tdata[REQ_W+SEL_W+TID_W-1:REQ_W+SEL_W];
    assign in_key = ID_WIDTH'(in_tid);
    assign in_q   = (32'(in_sel) < NUM_READY_QUEUES) ? QW'(in_sel) : QW'(NUM_READY_QUEUES);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign go            = (state_reg == ST_APPLY) && (!out_valid_reg || m_axis_tready);

    for (genvar k = 0; k < NQ; k++)
    begin : g_queue
        assign op_vec[k].insert = go && (req_reg == REQ_INSERT) && (q_reg == QW'(k));
        assign op_vec[k].remove = go && (req_reg == REQ_REMOVE) && (q_reg == QW'(k));

        tiqs_queue #(
            .DEPTH (QUEUE_DEPTH),
            .ID_W  (ID_WIDTH),
            .CNT_W (CNT_W)
        ) u_queue (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmp_en   (accept),
            .cmp_key  (in_key),
            .load_key (key_reg),
            .op       (op_vec[k]),
            .hit      (hit_vec[k]),
            .len      (len_vec[k])
        );
    end

    assign sel_hit = hit_vec[q_reg];
    assign sel_len = len_vec[q_reg];

    always_comb
    begin
        res_status = STAT_MISS;
        res_found  = '0;
        res_cnt    = '0;
        unique case (req_reg)
            REQ_INSERT:
            begin
                res_cnt = sel_len;
                if (sel_hit)
                begin
                    res_status = STAT_DUP;
                end
                else if (sel_len == CNT_W'(QUEUE_DEPTH))
                begin
                    res_status = STAT_FULL;
                end
                else
                begin
                    res_status = STAT_OK;
                    res_cnt    = sel_len + CNT_W'(1);
                end
            end
            REQ_REMOVE:
            begin
                res_cnt = sel_len;
                if (sel_hit)
                begin
                    res_status = STAT_OK;
                    res_cnt    = sel_len - CNT_W'(1);
                end
            end
            REQ_SEARCH:
            begin
                for (int k = NQ - 1; k >= 0; k--)
                begin
                    if (hit_vec[k])
                    begin
                        res_status = STAT_OK;
                        res_found  = FOUND_W'(k);
                    end
                end
            end
            default:
            begin
                res_status = STAT_MISS;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_req;
            q_reg   <= in_q;
            key_reg <= in_key;
        end
        if (go)
        begin
            status_reg <= res_status;
            found_reg  <= res_found;
            count_reg  <= COUNT_W'(res_cnt);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (OUT_DATA_W - STATUS_W - FOUND_W - COUNT_W)'(0),
        count_reg,
        found_reg,
        status_reg
    };

endmodule

// File: tb/thread_id_queue_set_unit_test.sv
// self-checking testbench for the thread id queue set with a predicting scoreboard
`timescale 1ns / 1ps

module thread_id_queue_set_unit_test;

    import tiqs_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int NUM_READY   = DEF_NUM_READY_QUEUES;
    localparam int NUM_QUEUES  = NUM_READY + 1;
    localparam int N_RANDOM    = 1500;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [SEL_W-1:0] SEL_READY0  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_READY1  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_READY2  = 2'd2;
    localparam logic [SEL_W-1:0] SEL_BLOCKED = 2'd3;

    localparam int RX_OPEN  = 0;
    localparam int RX_SHORT = 1;
    localparam int RX_LONG  = 2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_queue;
        logic [COUNT_W-1:0]  entry_count;
    } queue_result_t;

    class tid_queue_scoreboard;
        logic [TID_W-1:0] slot [NUM_QUEUES][DEPTH];
        int               fill [NUM_QUEUES];
        queue_result_t    expected_results [$];
        int               failures;
        int               checked;
        int               req_seen [4];
        int               status_seen [4];

        function new();
            failures = 0;
            checked  = 0;
            for (int k = 0; k < NUM_QUEUES; k++)
                fill[k] = 0;
            for (int k = 0; k < 4; k++)
            begin
                req_seen[k]    = 0;
                status_seen[k] = 0;
            end
        endfunction

        function int locate(input int q, input logic [TID_W-1:0] id);
            int pos;
            pos = -1;
            for (int i = 0; i < fill[q]; i++)
                if (pos < 0 && slot[q][i] == id)
                    pos = i;
            return pos;
        endfunction

        function void note_request(input logic [IN_DATA_W-1:0] word);
            logic [REQ_W-1:0] req;
            logic [SEL_W-1:0] sel;
            logic [TID_W-1:0] id;
            int               q;
            int               pos;
            queue_result_t    r;
            req = word[1:0];
            sel = word[3:2];
            id  = word[11:4];
            q   = (sel >= NUM_READY) ? NUM_READY : int'(sel);
            r.status      = STAT_MISS;
            r.found_queue = '0;
            r.entry_count = '0;
            case (req)
                REQ_INSERT:
                begin
                    if (locate(q, id) >= 0)
                        r.status = STAT_DUP;
                    else if (fill[q] >= DEPTH)
                        r.status = STAT_FULL;
                    else
                    begin
                        slot[q][fill[q]] = id;
                        fill[q]++;
                        r.status = STAT_OK;
                    end
                    r.entry_count = COUNT_W'(fill[q]);
                end
                REQ_REMOVE:
                begin
                    pos = locate(q, id);
                    if (pos >= 0)
                    begin
                        for (int i = pos; i + 1 < fill[q]; i++)
                            slot[q][i] = slot[q][i + 1];
                        fill[q]--;
                        r.status = STAT_OK;
                    end
                    r.entry_count = COUNT_W'(fill[q]);
                end
                REQ_SEARCH:
                begin
                    for (int k = 0; k < NUM_QUEUES; k++)
                        if (r.status != STAT_OK && locate(k, id) >= 0)
                        begin
                            r.status      = STAT_OK;
                            r.found_queue = FOUND_W'(k);
                        end
                end
                default: ;
            endcase
            req_seen[req]++;
            status_seen[r.status]++;
            expected_results.push_back(r);
        endfunction

        function void check_result(input logic [OUT_DATA_W-1:0] word);
            queue_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected: tdata %h", word);
                failures++;
                return;
            end
            e = expected_results.pop_front();
            checked++;
            if (word[1:0] !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, word[1:0]);
                failures++;
            end
            if (word[3:2] !== e.found_queue)
            begin
                $error("found_queue: expected %0d, actual %0d", e.found_queue, word[3:2]);
                failures++;
            end
            if (word[8:4] !== e.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d", e.entry_count, word[8:4]);
                failures++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int                    cycle_count = 0;
    int                    stall_left = 0;
    tid_queue_scoreboard   sb = new();

    thread_id_queue_set_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("thread_id_queue_set_unit_test NOT OK");
            $finish;
        end
    end

    // transaction monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata);
    end

    // receiver back-pressure, pattern steps through open, short stalls, long stalls and alternating ready
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            case ((cycle_count / 400) % 4)
                RX_OPEN:
                    m_axis_tready <= 1'b1;
                RX_SHORT:
                    if ($urandom_range(0, 3) == 0)
                    begin
                        m_axis_tready <= 1'b0;
                        stall_left    <= $urandom_range(0, 2);
                    end
                    else
                        m_axis_tready <= 1'b1;
                RX_LONG:
                    if ($urandom_range(0, 5) == 0)
                    begin
                        m_axis_tready <= 1'b0;
                        stall_left    <= $urandom_range(3, 14);
                    end
                    else
                        m_axis_tready <= 1'b1;
                default:
                    m_axis_tready <= cycle_count[0];
            endcase
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                                input logic [TID_W-1:0] id);
        s_axis_tdata  <= {4'b0000, id, sel, req};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic run_directed();
        send_request(REQ_INSERT, SEL_READY0, 8'h00);
        send_request(REQ_INSERT, SEL_READY0, 8'h00);
        send_request(REQ_INSERT, SEL_BLOCKED, 8'hAA);
        send_request(REQ_SEARCH, SEL_READY1, 8'hAA);
        send_request(REQ_SEARCH, SEL_BLOCKED, 8'h00);
        send_request(REQ_SEARCH, SEL_READY0, 8'h55);
        send_request(REQ_REMOVE, SEL_READY1, 8'h00);
        send_request(REQ_REMOVE, SEL_READY0, 8'h77);
        send_request(REQ_UNKNOWN, SEL_BLOCKED, 8'hFF);
        // fill one ready queue, then hit it when full
        for (int i = 0; i < DEPTH; i++)
            send_request(REQ_INSERT, SEL_READY2, TID_W'(8'hF0 + i));
        send_request(REQ_INSERT, SEL_READY2, 8'hF3);
        send_request(REQ_INSERT, SEL_READY2, 8'h00);
        send_request(REQ_REMOVE, SEL_READY2, 8'hF7);
        send_request(REQ_SEARCH, SEL_READY0, 8'hFF);
        send_request(REQ_REMOVE, SEL_READY0, 8'h00);
    endtask

    task automatic run_random();
        logic [REQ_W-1:0] req;
        logic [TID_W-1:0] id;
        int               burst_left;
        int               pool_base;
        int               pool_size;
        int               pick;
        burst_left = 0;
        pool_base  = 0;
        pool_size  = 20;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 250 == 0)
            begin
                pool_base = $urandom_range(0, 232);
                pool_size = $urandom_range(6, 24);
            end
            if (burst_left == 0)
            begin
                hold_off(((n / 100) % 3 == 0) ? 0 : $urandom_range(0, 10));
                burst_left = $urandom_range(1, 24);
            end
            // even phases fill the queues, odd phases drain them
            pick = $urandom_range(0, 99);
            if ((n / 250) % 2 == 0)
                req = (pick < 60) ? REQ_INSERT : (pick < 80) ? REQ_REMOVE :
                      (pick < 96) ? REQ_SEARCH : REQ_UNKNOWN;
            else
                req = (pick < 25) ? REQ_INSERT : (pick < 80) ? REQ_REMOVE :
                      (pick < 96) ? REQ_SEARCH : REQ_UNKNOWN;
            if ($urandom_range(0, 9) == 0)
                id = TID_W'($urandom_range(0, 255));
            else
                id = TID_W'(pool_base + $urandom_range(0, pool_size - 1));
            send_request(req, SEL_W'($urandom_range(0, 3)), id);
            burst_left--;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        run_random();
        for (int w = 0; w < 5000 && sb.pending() > 0; w++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (sb.pending() > 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.failures++;
        end
        $display("checked %0d results: %0d inserts, %0d removes, %0d searches, %0d unknown",
                 sb.checked, sb.req_seen[REQ_INSERT], sb.req_seen[REQ_REMOVE],
                 sb.req_seen[REQ_SEARCH], sb.req_seen[REQ_UNKNOWN]);
        $display("outcomes: %0d ok, %0d duplicate, %0d miss, %0d full",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_DUP],
                 sb.status_seen[STAT_MISS], sb.status_seen[STAT_FULL]);
        if (sb.failures == 0)
            $display("thread_id_queue_set_unit_test OK");
        else
            $display("thread_id_queue_set_unit_test NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tiqs_pkg.sv
rtl/tiqs_cell.sv
rtl/tiqs_queue.sv
rtl/thread_id_queue_set_unit.sv
tb/thread_id_queue_set_unit_test.sv
